// ----- design/bnmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bnmc_pkg
// Shared constants, register map and helpers for the network mean cell.
// ----------------------------------------------------------------------------
package bnmc_pkg;

   localparam int unsigned FRAC_BITS = 16;
   localparam logic [1:0]  MAX_RANK  = 2'd2;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int unsigned ADD_WIDTH   = VALUE_WIDTH + 2;
   localparam int unsigned CSR_AWIDTH  = 5;

   typedef enum logic [2:0] {
      CSR_RANK_ROWS = 3'd0,
      CSR_RANK_COLS = 3'd1,
      CSR_G_00      = 3'd2,
      CSR_G_01      = 3'd3,
      CSR_G_10      = 3'd4,
      CSR_G_11      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                            clipped;
      logic signed [VALUE_WIDTH-1:0]   value;
   } clip_type;

   // clip a wide signed value to the signed 32-bit range
   function automatic clip_type clip32(input logic signed [PROD_WIDTH-1:0] x);
      clip_type r;
      r.clipped = 1'b0;
      r.value   = x[VALUE_WIDTH-1:0];
      if (!x[PROD_WIDTH-1] && (x[PROD_WIDTH-2:VALUE_WIDTH-1] != '0)) begin
         r.clipped = 1'b1;
         r.value   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end else if (x[PROD_WIDTH-1] && (x[PROD_WIDTH-2:VALUE_WIDTH-1] != '1)) begin
         r.clipped = 1'b1;
         r.value   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end
      return r;
   endfunction

   // ranks above the supported maximum count as the maximum
   function automatic logic [1:0] limit_rank(input logic [1:0] r);
      return (r > MAX_RANK) ? MAX_RANK : r;
   endfunction

endpackage

// ----- design/bilinear_network_mean_cell_top.sv -----
// ----------------------------------------------------------------------------
// bilinear_network_mean_cell_top
// Expected cell value base + a + b + u'Gv in Q16.16 with saturation.
// ----------------------------------------------------------------------------
// One cell word is accepted per clock while the output is not stalled; its
// result passes through the register stages of the pipeline: the u*G products,
// the row sums with clipping of w, the w*v products, and the final add with
// clipping. A stalled output holds the pipe stage by stage, so bubbles are
// squeezed out. Registers (rank_rows, rank_cols, g_00..g_11) are to be written
// over the csr port only while no word is in flight; the block does not enforce
// this. Ranks above two count as two, a rank of zero drops the bilinear term.
// saturated is set when w or the final sum clipped.
module bilinear_network_mean_cell_top
   import bnmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // base_value, row_effect, col_effect, u0, u1, v0, v1 (32 bits each, low up)
   input  logic [223:0]          req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ez_value
   output logic [31:0]           rsp_tdata,
   // saturated
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_AWIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // ---------------- registers ----------------
   logic [1:0]                    rank_rows_ff, rank_cols_ff;
   logic signed [VALUE_WIDTH-1:0] g00_ff, g01_ff, g10_ff, g11_ff;
   csr_index_type                 csr_index;
   logic                          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_rows_ff <= '0;
         rank_cols_ff <= '0;
         g00_ff       <= '0;
         g01_ff       <= '0;
         g10_ff       <= '0;
         g11_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RANK_ROWS: rank_rows_ff <= csr_pwdata[1:0];
            CSR_RANK_COLS: rank_cols_ff <= csr_pwdata[1:0];
            CSR_G_00:      g00_ff       <= csr_pwdata;
            CSR_G_01:      g01_ff       <= csr_pwdata;
            CSR_G_10:      g10_ff       <= csr_pwdata;
            CSR_G_11:      g11_ff       <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_RANK_ROWS: csr_prdata = {30'd0, rank_rows_ff};
         CSR_RANK_COLS: csr_prdata = {30'd0, rank_cols_ff};
         CSR_G_00:      csr_prdata = g00_ff;
         CSR_G_01:      csr_prdata = g01_ff;
         CSR_G_10:      csr_prdata = g10_ff;
         CSR_G_11:      csr_prdata = g11_ff;
         default:       csr_prdata = '0;
      endcase
   end

   logic [1:0] rank_rows_eff, rank_cols_eff;
   logic [1:0] row_use, col_use;

   assign rank_rows_eff = limit_rank(rank_rows_ff);
   assign rank_cols_eff = limit_rank(rank_cols_ff);
   assign row_use       = {rank_rows_eff > 2'd1, rank_rows_eff > 2'd0};
   assign col_use       = {rank_cols_eff > 2'd1, rank_cols_eff > 2'd0};

   // ---------------- stage flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv     = !s4_valid_ff | rsp_tready;
   assign s3_adv     = !s3_valid_ff | s4_adv;
   assign s2_adv     = !s2_valid_ff | s3_adv;
   assign s1_adv     = !s1_valid_ff | s2_adv;
   assign req_tready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= req_tvalid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
         if (s4_adv) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: u*G products, additive sum ----------------
   logic signed [VALUE_WIDTH-1:0] base_value, row_effect, col_effect;
   logic signed [VALUE_WIDTH-1:0] u0, u1, v0, v1;

   assign base_value = $signed(req_tdata[31:0]);
   assign row_effect = $signed(req_tdata[63:32]);
   assign col_effect = $signed(req_tdata[95:64]);
   assign u0         = $signed(req_tdata[127:96]);
   assign u1         = $signed(req_tdata[159:128]);
   assign v0         = $signed(req_tdata[191:160]);
   assign v1         = $signed(req_tdata[223:192]);

   logic signed [PROD_WIDTH-1:0]  s1_p00_in, s1_p01_in, s1_p10_in, s1_p11_in;
   logic signed [PROD_WIDTH-1:0]  s1_p00_ff, s1_p01_ff, s1_p10_ff, s1_p11_ff;
   logic signed [ADD_WIDTH-1:0]   s1_add_in, s1_add_ff;
   logic signed [VALUE_WIDTH-1:0] s1_v0_ff, s1_v1_ff;

   assign s1_p00_in = PROD_WIDTH'(u0) * PROD_WIDTH'(g00_ff);
   assign s1_p01_in = PROD_WIDTH'(u0) * PROD_WIDTH'(g01_ff);
   assign s1_p10_in = PROD_WIDTH'(u1) * PROD_WIDTH'(g10_ff);
   assign s1_p11_in = PROD_WIDTH'(u1) * PROD_WIDTH'(g11_ff);
   assign s1_add_in = ADD_WIDTH'(base_value) + ADD_WIDTH'(row_effect)
                    + ADD_WIDTH'(col_effect);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_p00_ff <= s1_p00_in;
         s1_p01_ff <= s1_p01_in;
         s1_p10_ff <= s1_p10_in;
         s1_p11_ff <= s1_p11_in;
         s1_add_ff <= s1_add_in;
         s1_v0_ff  <= v0;
         s1_v1_ff  <= v1;
      end
   end

   // ---------------- stage 2: w_j row sums with clipping ----------------
   // signed zero keeps the shifts below arithmetic
   localparam logic signed [PROD_WIDTH-1:0] WIDE_ZERO = '0;

   logic signed [PROD_WIDTH-1:0]  w0_sum, w1_sum;
   clip_type                      w0_clip, w1_clip;
   logic signed [VALUE_WIDTH-1:0] s2_w0_in, s2_w1_in, s2_w0_ff, s2_w1_ff;
   logic                          s2_sat_in, s2_sat_ff;
   logic signed [ADD_WIDTH-1:0]   s2_add_ff;
   logic signed [VALUE_WIDTH-1:0] s2_v0_ff, s2_v1_ff;

   always_comb begin
      w0_sum  = (row_use[0] ? (s1_p00_ff >>> FRAC_BITS) : WIDE_ZERO)
              + (row_use[1] ? (s1_p10_ff >>> FRAC_BITS) : WIDE_ZERO);
      w1_sum  = (row_use[0] ? (s1_p01_ff >>> FRAC_BITS) : WIDE_ZERO)
              + (row_use[1] ? (s1_p11_ff >>> FRAC_BITS) : WIDE_ZERO);
      w0_clip = clip32(w0_sum);
      w1_clip = clip32(w1_sum);
      // unused columns contribute nothing and never flag
      s2_w0_in  = col_use[0] ? w0_clip.value : '0;
      s2_w1_in  = col_use[1] ? w1_clip.value : '0;
      s2_sat_in = (col_use[0] & w0_clip.clipped) | (col_use[1] & w1_clip.clipped);
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_w0_ff  <= s2_w0_in;
         s2_w1_ff  <= s2_w1_in;
         s2_sat_ff <= s2_sat_in;
         s2_add_ff <= s1_add_ff;
         s2_v0_ff  <= s1_v0_ff;
         s2_v1_ff  <= s1_v1_ff;
      end
   end

   // ---------------- stage 3: w*v products ----------------
   logic signed [PROD_WIDTH-1:0] s3_q0_in, s3_q1_in, s3_q0_ff, s3_q1_ff;
   logic                         s3_sat_ff;
   logic signed [ADD_WIDTH-1:0]  s3_add_ff;

   assign s3_q0_in = PROD_WIDTH'(s2_w0_ff) * PROD_WIDTH'(s2_v0_ff);
   assign s3_q1_in = PROD_WIDTH'(s2_w1_ff) * PROD_WIDTH'(s2_v1_ff);

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_q0_ff  <= s3_q0_in;
         s3_q1_ff  <= s3_q1_in;
         s3_sat_ff <= s2_sat_ff;
         s3_add_ff <= s2_add_ff;
      end
   end

   // ---------------- stage 4: final sum, clipping, output word ----------------
   logic signed [PROD_WIDTH-1:0]  total_sum;
   clip_type                      total_clip;
   logic signed [VALUE_WIDTH-1:0] s4_value_ff;
   logic                          s4_sat_in, s4_sat_ff;

   always_comb begin
      total_sum  = PROD_WIDTH'(s3_add_ff) + (s3_q0_ff >>> FRAC_BITS)
                 + (s3_q1_ff >>> FRAC_BITS);
      total_clip = clip32(total_sum);
      s4_sat_in  = s3_sat_ff | total_clip.clipped;
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_value_ff <= total_clip.value;
         s4_sat_ff   <= s4_sat_in;
      end
   end

   assign rsp_tvalid   = s4_valid_ff;
   assign rsp_tdata    = s4_value_ff;
   assign rsp_tuser[0] = s4_sat_ff;

endmodule

// ----- tb/bilinear_network_mean_cell_top_test.sv -----
// ----------------------------------------------------------------------------
// bilinear_network_mean_cell_top_test
// Self-checking bench for the network mean cell: base + a + b + u'Gv.
// Cell words stream in through a queue-fed driver and each result is compared
// against a local Q16.16 model of the cell arithmetic, including the clipping
// of the inner row sums and of the final sum. Registers are reloaded between
// phases with the pipe empty, and sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module bilinear_network_mean_cell_top_test;
   import bnmc_pkg::*;

   localparam int unsigned HALF_PERIOD   = 2;
   localparam int unsigned LIMIT_CYCLES  = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned NUM_PHASES    = 12;
   localparam int unsigned PHASE_CELLS   = 158;
   localparam int unsigned HOLD_PHASE    = 4;
   localparam int unsigned HOLD_CYCLES   = 500;
   localparam int unsigned REPORT_LIMIT  = 10;

   // addresses past the register map, writes there must not land
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;
   localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] Q16_ONE  = 32'sh0001_0000;
   localparam longint             WIDE_MAX = 64'sd2147483647;
   localparam longint             WIDE_MIN = -WIDE_MAX - 1;

   // packed so that base_value lands in the low bits of req_tdata
   typedef struct packed {
      logic signed [31:0] v1;
      logic signed [31:0] v0;
      logic signed [31:0] u1;
      logic signed [31:0] u0;
      logic signed [31:0] col_effect;
      logic signed [31:0] row_effect;
      logic signed [31:0] base_value;
   } cell_word_type;

   typedef struct {
      logic signed [31:0] ez_value;
      logic               saturated;
   } cell_value_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic [223:0]          req_tdata    = '0;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [31:0]           rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_AWIDTH-1:0] csr_paddr    = '0;
   logic [31:0]           csr_pwdata   = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   bilinear_network_mean_cell_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // local copy of the register file
   logic [1:0]         rank_rows_cfg = '0;
   logic [1:0]         rank_cols_cfg = '0;
   logic signed [31:0] g_cfg [2][2]  = '{'{0, 0}, '{0, 0}};

   cell_word_type  pending_cells [$];
   cell_value_type expected_cells [$];
   cell_word_type  cell_on_bus;
   int unsigned cells_offered  = 0;
   int unsigned cells_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned fail_count     = 0;
   int unsigned directed_cells = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        rsp_hold       = 1'b0;
   event        rsp_hold_go;

   function automatic longint clamp_wide(input longint x, inout logic hit);
      if (x > WIDE_MAX) begin
         hit = 1'b1;
         return WIDE_MAX;
      end
      if (x < WIDE_MIN) begin
         hit = 1'b1;
         return WIDE_MIN;
      end
      return x;
   endfunction

   function automatic cell_value_type predict_cell(input cell_word_type c);
      longint         u_vec [2];
      longint         v_vec [2];
      longint         w;
      longint         term;
      longint         total;
      int             rows_used;
      int             cols_used;
      logic           clipped;
      cell_value_type r;
      rows_used = (rank_rows_cfg > MAX_RANK) ? int'(MAX_RANK) : int'(rank_rows_cfg);
      cols_used = (rank_cols_cfg > MAX_RANK) ? int'(MAX_RANK) : int'(rank_cols_cfg);
      u_vec[0]  = c.u0;
      u_vec[1]  = c.u1;
      v_vec[0]  = c.v0;
      v_vec[1]  = c.v1;
      term      = 0;
      clipped   = 1'b0;
      for (int j = 0; j < cols_used; j++) begin
         w = 0;
         for (int i = 0; i < rows_used; i++)
            w += (u_vec[i] * longint'(g_cfg[i][j])) >>> FRAC_BITS;
         w = clamp_wide(w, clipped);
         term += (w * v_vec[j]) >>> FRAC_BITS;
      end
      total       = longint'(c.base_value) + longint'(c.row_effect)
                    + longint'(c.col_effect) + term;
      r.ez_value  = 32'(clamp_wide(total, clipped));
      r.saturated = clipped;
      return r;
   endfunction

   // mostly moderate values so that sums stay in range, with extremes and full words
   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(15))
         0, 1: begin
            case ($urandom_range(6))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return 32'sd0;
               3: return 32'sd1;
               4: return -32'sd1;
               5: return Q16_ONE;
               default: return -Q16_ONE;
            endcase
         end
         2, 3, 4, 5: return $urandom;
         default: return int'($urandom_range(2097152)) - 1048576;
      endcase
   endfunction

   function automatic cell_word_type make_cell(
      input logic signed [31:0] base_value, row_effect, col_effect,
      input logic signed [31:0] u0, u1, v0, v1);
      cell_word_type c;
      c.base_value = base_value;
      c.row_effect = row_effect;
      c.col_effect = col_effect;
      c.u0         = u0;
      c.u1         = u1;
      c.v0         = v0;
      c.v1         = v1;
      return c;
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AWIDTH'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         CSR_RANK_ROWS: rank_rows_cfg = value[1:0];
         CSR_RANK_COLS: rank_cols_cfg = value[1:0];
         CSR_G_00:      g_cfg[0][0]   = value;
         CSR_G_01:      g_cfg[0][1]   = value;
         CSR_G_10:      g_cfg[1][0]   = value;
         CSR_G_11:      g_cfg[1][1]   = value;
         default: ;
      endcase
   endtask

   task automatic load_ranks(input logic [1:0] rows, input logic [1:0] cols);
      csr_write(CSR_RANK_ROWS, {30'd0, rows});
      csr_write(CSR_RANK_COLS, {30'd0, cols});
   endtask

   task automatic load_matrix(input logic signed [31:0] g00, g01, g10, g11);
      csr_write(CSR_G_00, g00);
      csr_write(CSR_G_01, g01);
      csr_write(CSR_G_10, g10);
      csr_write(CSR_G_11, g11);
   endtask

   // pipe empty: nothing queued, nothing on the bus, every result back
   task automatic wait_drained();
      while (pending_cells.size() != 0 || cells_offered != cells_accepted ||
             expected_cells.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_directed(input cell_word_type c);
      pending_cells.push_back(c);
      directed_cells++;
   endtask

   // cell driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_cells.push_back(predict_cell(cell_on_bus));
            cells_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cell_on_bus = pending_cells.pop_front();
               cells_offered++;
               req_tdata  <= cell_on_bus;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_check
      cell_value_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_cells.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected word %0d: value %h sat %b", results_seen,
                           rsp_tdata, rsp_tuser[0]);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata !== want.ez_value || rsp_tuser[0] !== want.saturated) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("word %0d: expected value %h sat %b, got value %h sat %b",
                              results_seen, want.ez_value, want.saturated,
                              rsp_tdata, rsp_tuser[0]);
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off so the pipe fills and backs up into the input
   initial begin
      forever begin
         @(rsp_hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout with %0d words still expected", expected_cells.size());
      $display("** bilinear_network_mean_cell_top: FAILED **");
      $finish;
   end

   initial begin : stimulus
      cell_word_type      c;
      logic [1:0]         rows;
      logic [1:0]         cols;
      logic signed [31:0] g [4];
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset ranks: no bilinear term, final sum clipping both ways
      push_directed(make_cell(0, 0, 0, 0, 0, 0, 0));
      push_directed(make_cell(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
      push_directed(make_cell(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
      push_directed(make_cell(VAL_MAX, 1, -1, $urandom, $urandom, $urandom, $urandom));
      push_directed(make_cell(VAL_MIN, -1, 1, $urandom, $urandom, $urandom, $urandom));
      wait_drained();

      // identity matrix with ranks still zero, then writes past the map
      load_matrix(Q16_ONE, 0, 0, Q16_ONE);
      csr_write(CSR_SPARE_A, $urandom);
      csr_write(CSR_SPARE_B, $urandom);
      push_directed(make_cell(Q16_ONE, 0, 0, 2 * Q16_ONE, 0, 3 * Q16_ONE, 0));
      wait_drained();

      load_ranks(2'd2, 2'd2);
      push_directed(make_cell(Q16_ONE, 0, 0, 2 * Q16_ONE, -(3 * Q16_ONE / 2),
                              3 * Q16_ONE, Q16_ONE / 2));
      // negative lsb: the shifts round toward minus infinity
      push_directed(make_cell(0, 0, 0, -1, 0, 1, 0));
      push_directed(make_cell(0, 0, 0, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
      wait_drained();

      // inner row sum clips while the final sum stays in range
      load_matrix(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
      push_directed(make_cell(0, 0, 0, VAL_MAX, VAL_MAX, 0, 0));
      push_directed(make_cell(0, 0, 0, VAL_MIN, VAL_MIN, 1, 1));
      wait_drained();
      load_matrix(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
      push_directed(make_cell(0, 0, 0, VAL_MIN, VAL_MIN, -Q16_ONE, 0));
      push_directed(make_cell(VAL_MAX, VAL_MIN, 0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN));
      wait_drained();

      // rank three counts as two
      load_matrix(rand_value(), rand_value(), rand_value(), rand_value());
      load_ranks(2'd3, 2'd3);
      push_directed(make_cell(rand_value(), rand_value(), rand_value(),
                              rand_value(), rand_value(), rand_value(), rand_value()));
      push_directed(make_cell(0, 0, 0, Q16_ONE, -Q16_ONE, Q16_ONE, -Q16_ONE));
      wait_drained();

      // mixed ranks, including zero on one side only
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: load_ranks(2'd1, 2'd2);
            1: load_ranks(2'd2, 2'd1);
            2: load_ranks(2'd0, 2'd2);
            default: load_ranks(2'd2, 2'd0);
         endcase
         push_directed(make_cell(rand_value(), rand_value(), rand_value(),
                                 rand_value(), rand_value(), rand_value(), rand_value()));
         push_directed(make_cell(0, 0, 0, Q16_ONE, 2 * Q16_ONE, -Q16_ONE, 3 * Q16_ONE));
         wait_drained();
      end

      // random phases, each with its own registers and idling mix
      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 48; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 48; end
            default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
         endcase
         case (phase)
            0: begin rows = 2'd2; cols = 2'd2; end
            1: begin rows = 2'd3; cols = 2'd3; end
            2: begin rows = 2'd2; cols = 2'd3; end
            3: begin rows = 2'd1; cols = 2'd2; end
            4: begin rows = 2'd2; cols = 2'd1; end
            5: begin rows = 2'd0; cols = 2'd2; end
            6: begin rows = 2'd2; cols = 2'd0; end
            default: begin
               rows = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd2;
               cols = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd2;
            end
         endcase
         for (int k = 0; k < 4; k++)
            case (phase)
               1: g[k] = VAL_MAX;
               2: g[k] = VAL_MIN;
               default: g[k] = rand_value();
            endcase
         load_ranks(rows, cols);
         load_matrix(g[0], g[1], g[2], g[3]);
         for (int unsigned n = 0; n < PHASE_CELLS; n++) begin
            c.base_value = rand_value();
            c.row_effect = rand_value();
            c.col_effect = rand_value();
            c.u0         = rand_value();
            c.u1         = rand_value();
            c.v0         = rand_value();
            c.v1         = rand_value();
            pending_cells.push_back(c);
         end
         if (phase == HOLD_PHASE)
            -> rsp_hold_go;
         wait_drained();
      end

      fail_count += expected_cells.size();
      $display("ran %0d cells (%0d directed) through %0d random register settings",
               cells_accepted, directed_cells, NUM_PHASES);
      $display("checked %0d result words, %0d failures", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("** bilinear_network_mean_cell_top: PASSED **");
      end else begin
         $display("** bilinear_network_mean_cell_top: FAILED **");
      end
      $finish;
   end

endmodule
